// File: src/nfsa_pkg.sv
`timescale 1ns / 1ps
// Package for the next-fit slot allocator: field widths, command codes and
// the default pool size. It depends on nothing else.
package nfsa_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int CMD_W         = 2;
    localparam int ID_W          = 8;
    localparam int CNT_OUT_W     = 9;
    localparam int CFG_W         = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_ANY = 2'd0,
        CMD_ALLOC_ID  = 2'd1,
        CMD_FREE      = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

endpackage

// File: src/nfsa_req_if.sv
`timescale 1ns / 1ps
// Request channel of the slot allocator: command and slot index.
// It depends on nfsa_pkg for the field widths.
interface nfsa_req_if;
    import nfsa_pkg::*;

    logic            valid;
    logic            ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  slot_id;

    modport source (output valid, output cmd, output slot_id, input ready);
    modport sink   (input valid, input cmd, input slot_id, output ready);
endinterface

// File: src/nfsa_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the slot allocator: success, slot and free count.
// It depends on nfsa_pkg for the field widths.
interface nfsa_rsp_if;
    import nfsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [ID_W-1:0]      granted_slot;
    logic [CNT_OUT_W-1:0] free_count;

    modport source (output valid, output ok, output granted_slot, output free_count,
                    input ready);
    modport sink   (input valid, input ok, input granted_slot, input free_count,
                    output ready);
endinterface

// File: src/nfsa_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the slot allocator: the active slot count.
// It depends on nfsa_pkg for the register width.
interface nfsa_cfg_if;
    import nfsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/nfsa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module nfsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/next_fit_slot_allocator.sv
`timescale 1ns / 1ps
// Top level of the next-fit slot allocator. It depends on nfsa_pkg, the three
// channel interfaces and nfsa_ram, which holds one busy bit per slot.
// Allocate-any reads one busy bit per cycle from the RAM port while it scans;
// allocate-specific and free pass through the lookup and check states; a full
// pool, an out-of-range slot or an unused command goes straight to the done
// state. One transaction is in flight at a time.
// After reset and after every configuration write, a clearing pass over all
// MAX_SLOTS slots writes every busy bit to zero while no request is accepted.
module next_fit_slot_allocator #(
    parameter int MAX_SLOTS = nfsa_pkg::MAX_SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    nfsa_req_if.sink   req,
    nfsa_rsp_if.source rsp,
    nfsa_cfg_if.sink   cfg
);
    import nfsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_LOOKUP = 6'b001000,
        ST_CHECK  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] active_reg, active_next;
    logic [W-1:0]     busy_reg, busy_next;
    logic [IDX_W-1:0] search_reg, search_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] rd_pos_reg, rd_pos_next;
    logic [IDX_W-1:0] chk_pos_reg, chk_pos_next;
    logic             chk_vld_reg, chk_vld_next;
    cmd_t             cmd_reg, cmd_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             ok_reg, ok_next;
    logic [ID_W-1:0]  slot_reg, slot_next;

    logic [W-1:0]     n_slots;
    logic [W-1:0]     req_id_w;
    logic [W-1:0]     id_w;
    logic [W-1:0]     chk_pos_w;
    logic [W-1:0]     free_w;
    logic [IDX_W-1:0] id_addr;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] pos,
                                                 input logic [W-1:0] lim);
        logic [W-1:0] nxt;
        nxt = W'(pos) + W'(1);
        return (nxt >= lim) ? '0 : nxt[IDX_W-1:0];
    endfunction

    assign n_slots   = (W'(active_reg) > W'(MAX_SLOTS)) ? W'(MAX_SLOTS) : W'(active_reg);
    assign req_id_w  = W'(req.slot_id);
    assign id_w      = W'(id_reg);
    assign id_addr   = id_w[IDX_W-1:0];
    assign chk_pos_w = W'(chk_pos_reg);
    assign free_w    = n_slots - busy_reg;

    assign req.ready        = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = (state_reg == ST_DONE);
    assign rsp.ok           = ok_reg;
    assign rsp.granted_slot = slot_reg;
    assign rsp.free_count   = free_w[CNT_OUT_W-1:0];

    assign ram_raddr = (state_reg == ST_SCAN) ? rd_pos_reg : id_addr;

    nfsa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        busy_next    = busy_reg;
        search_next  = search_reg;
        clr_next     = clr_reg;
        rd_pos_next  = rd_pos_reg;
        chk_pos_next = chk_pos_reg;
        chk_vld_next = chk_vld_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        ok_next      = ok_reg;
        slot_next    = slot_reg;
        ram_we       = 1'b0;
        ram_waddr    = clr_reg;
        ram_wdata    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next  = cmd_t'(req.cmd);
                    id_next   = req.slot_id;
                    ok_next   = 1'b0;
                    slot_next = '0;
                    unique case (cmd_t'(req.cmd))
                        CMD_ALLOC_ANY:
                        begin
                            if (busy_reg >= n_slots)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                rd_pos_next  = search_reg;
                                chk_vld_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                        CMD_ALLOC_ID, CMD_FREE:
                        begin
                            state_next = (req_id_w < n_slots) ? ST_LOOKUP : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Reads are issued one slot per cycle; the data of the previous
                // address is checked in the same cycle.
                rd_pos_next  = advance(rd_pos_reg, n_slots);
                chk_pos_next = rd_pos_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg && !ram_rdata)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = chk_pos_reg;
                    ram_wdata   = 1'b1;
                    busy_next   = busy_reg + W'(1);
                    ok_next     = 1'b1;
                    slot_next   = chk_pos_w[ID_W-1:0];
                    search_next = advance(chk_pos_reg, n_slots);
                    state_next  = ST_DONE;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_ALLOC_ID)
                begin
                    if (!ram_rdata)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = id_addr;
                        ram_wdata   = 1'b1;
                        busy_next   = busy_reg + W'(1);
                        ok_next     = 1'b1;
                        slot_next   = id_reg;
                        search_next = advance(id_addr, n_slots);
                    end
                end
                else
                begin
                    if (ram_rdata)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = id_addr;
                        ram_wdata = 1'b0;
                        if (busy_reg != '0)
                        begin
                            busy_next = busy_reg - W'(1);
                        end
                    end
                    ok_next   = 1'b1;
                    slot_next = id_reg;
                end
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (cfg.valid)
        begin
            active_next = cfg.data;
            busy_next   = '0;
            search_next = '0;
            clr_next    = '0;
            state_next  = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            active_reg  <= CFG_W'(256);
            busy_reg    <= '0;
            search_reg  <= '0;
            clr_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            busy_reg    <= busy_next;
            search_reg  <= search_next;
            clr_reg     <= clr_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg  <= rd_pos_next;
        chk_pos_reg <= chk_pos_next;
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        ok_reg      <= ok_next;
        slot_reg    <= slot_next;
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for next_fit_slot_allocator: a directed table and then random
// phases, each with its own pool size. It depends on nfsa_pkg and the channel interfaces.
module testbench;
    import nfsa_pkg::*;

    localparam int POOL_MAX = MAX_SLOTS_DEF;

    typedef enum logic {
        STEP_REQ = 1'b0,
        STEP_CFG = 1'b1
    } step_kind_t;

    typedef struct packed {
        logic                 ok;
        logic [ID_W-1:0]      slot;
        logic [CNT_OUT_W-1:0] free_cnt;
    } outcome_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_W-1:0]     cfg_value;
        cmd_t                 op;
        logic [ID_W-1:0]      slot_id;
        logic                 fixed;
        logic                 want_ok;
        logic [ID_W-1:0]      want_slot;
        logic [CNT_OUT_W-1:0] want_free;
    } step_t;

    localparam step_t PLAN [26] = '{
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b1, 1'b1, 8'd0,   9'd255},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd200, 1'b1, 1'b1, 8'd1,   9'd254},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd255, 1'b1, 1'b1, 8'd255, 9'd253},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd1,   1'b1, 1'b0, 8'd0,   9'd252},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd1,   1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd1,   1'b1, 1'b1, 8'd1,   9'd253},
        '{STEP_REQ, 9'd0,   CMD_NONE,      8'd170, 1'b1, 1'b0, 8'd0,   9'd253},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd85,  1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd128, 1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd255, 1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd255, 1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_CFG, 9'd1,   CMD_NONE,      8'd0,   1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b1, 1'b1, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd1,   1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd255, 1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd0,   1'b1, 1'b1, 8'd0,   9'd1},
        '{STEP_CFG, 9'd0,   CMD_NONE,      8'd0,   1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_FREE,      8'd0,   1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd0,   1'b1, 1'b0, 8'd0,   9'd0},
        '{STEP_CFG, 9'd511, CMD_NONE,      8'd0,   1'b0, 1'b0, 8'd0,   9'd0},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ID,  8'd255, 1'b1, 1'b1, 8'd255, 9'd255},
        '{STEP_REQ, 9'd0,   CMD_ALLOC_ANY, 8'd0,   1'b1, 1'b1, 8'd0,   9'd254},
        '{STEP_REQ, 9'd0,   CMD_NONE,      8'd0,   1'b1, 1'b0, 8'd0,   9'd254}
    };

    logic clk;
    logic rst_n;

    nfsa_req_if req_ch ();
    nfsa_rsp_if rsp_ch ();
    nfsa_cfg_if cfg_ch ();

    next_fit_slot_allocator #(
        .MAX_SLOTS(POOL_MAX)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    bit          slot_taken [POOL_MAX];
    int unsigned cursor;
    int unsigned taken_total;
    int unsigned pool_len;
    outcome_t    owed_replies [$];
    int          err_count;
    bit          steady;

    function automatic int unsigned wrap_next(int unsigned pos);
        return (pos + 1 >= pool_len) ? 0 : pos + 1;
    endfunction

    function automatic void reset_pool(logic [CFG_W-1:0] value);
        pool_len = (value > POOL_MAX) ? POOL_MAX : value;
        foreach (slot_taken[k])
        begin
            slot_taken[k] = 1'b0;
        end
        cursor = 0;
        taken_total = 0;
    endfunction

    function automatic outcome_t pool_outcome(cmd_t op, logic [ID_W-1:0] id);
        outcome_t    res;
        int unsigned pos;
        res = '0;
        case (op)
            CMD_ALLOC_ANY:
            begin
                pos = cursor;
                for (int i = 0; i < pool_len; i++)
                begin
                    if (!slot_taken[pos])
                    begin
                        slot_taken[pos] = 1'b1;
                        taken_total++;
                        res.ok = 1'b1;
                        res.slot = pos[ID_W-1:0];
                        cursor = wrap_next(pos);
                        break;
                    end
                    pos = wrap_next(pos);
                end
            end
            CMD_ALLOC_ID:
            begin
                if (id < pool_len && !slot_taken[id])
                begin
                    slot_taken[id] = 1'b1;
                    taken_total++;
                    res.ok = 1'b1;
                    res.slot = id;
                    cursor = wrap_next(id);
                end
            end
            CMD_FREE:
            begin
                if (id < pool_len)
                begin
                    if (slot_taken[id])
                    begin
                        slot_taken[id] = 1'b0;
                        taken_total--;
                    end
                    res.ok = 1'b1;
                    res.slot = id;
                end
            end
            default:
            begin
            end
        endcase
        res.free_cnt = CNT_OUT_W'(pool_len - taken_total);
        return res;
    endfunction

    function automatic int idle_span();
        return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= 100)
        begin
            $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        end
    endtask

    task automatic send_request(cmd_t op, logic [ID_W-1:0] id, logic fixed, outcome_t typed);
        outcome_t want;
        int       gap;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= op;
        req_ch.slot_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        want = pool_outcome(op, id);
        if (fixed)
        begin
            want = typed;
        end
        owed_replies.push_back(want);
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_active_slots(logic [CFG_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reset_pool(value);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (steady || $urandom_range(0, 99) < 60)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat (idle_span()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_replies.size() == 0)
            begin
                report_mismatch("unexpected response, ok", rsp_ch.ok, 0);
            end
            else
            begin
                want = owed_replies.pop_front();
                if (rsp_ch.ok !== want.ok)
                begin
                    report_mismatch("ok", rsp_ch.ok, want.ok);
                end
                if (rsp_ch.granted_slot !== want.slot)
                begin
                    report_mismatch("granted_slot", rsp_ch.granted_slot, want.slot);
                end
                if (rsp_ch.free_count !== want.free_cnt)
                begin
                    report_mismatch("free_count", rsp_ch.free_count, want.free_cnt);
                end
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("next_fit_slot_allocator regression: fail");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] size_pick;
        int               alloc_pct;
        int               count;
        int               r;
        cmd_t             op;
        logic [ID_W-1:0]  id;
        err_count = 0;
        steady = 1'b0;
        reset_pool(9'd256);
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= CMD_NONE;
        req_ch.slot_id <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < $size(PLAN); k++)
        begin
            if (PLAN[k].kind == STEP_CFG)
            begin
                write_active_slots(PLAN[k].cfg_value);
            end
            else
            begin
                send_request(PLAN[k].op, PLAN[k].slot_id, PLAN[k].fixed,
                             '{PLAN[k].want_ok, PLAN[k].want_slot, PLAN[k].want_free});
            end
        end

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: size_pick = 9'd256;
                1: size_pick = 9'd1;
                2: size_pick = CFG_W'($urandom_range(2, 8));
                3: size_pick = 9'd255;
                4: size_pick = 9'd0;
                5: size_pick = CFG_W'($urandom_range(9, 64));
                6: size_pick = CFG_W'($urandom_range(257, 511));
                7: size_pick = CFG_W'($urandom_range(2, 16));
                default: size_pick = CFG_W'($urandom_range(1, 256));
            endcase
            write_active_slots(size_pick);
            steady = (phase % 3 == 1);
            alloc_pct = (pool_len > 128) ? 80 : $urandom_range(40, 75);
            count = (pool_len == 0) ? 30 : 195;
            for (int n = 0; n < count; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    op = CMD_NONE;
                end
                else if (r < 4 + alloc_pct)
                begin
                    op = ($urandom_range(0, 9) < 6) ? CMD_ALLOC_ANY : CMD_ALLOC_ID;
                end
                else
                begin
                    op = CMD_FREE;
                end
                if (pool_len > 0 && $urandom_range(0, 4) != 0)
                begin
                    id = ID_W'($urandom_range(0, pool_len - 1));
                end
                else
                begin
                    id = ID_W'($urandom_range(0, 255));
                end
                send_request(op, id, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        steady = 1'b0;
        while (owed_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (POOL_MAX + 8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("next_fit_slot_allocator regression: pass");
        end
        else
        begin
            $display("next_fit_slot_allocator regression: fail");
        end
        $finish;
    end

endmodule
